// ===== hdl/clex_pkg.sv =====
// ----------------------------------------------------------------------------
// clex_pkg: shared types, codes and lexing functions for the C-style lexer
// Holds the lexer state record, the result record and the per-byte step.
// ----------------------------------------------------------------------------
package clex_pkg;

	localparam int POS_W = 16;
	typedef logic [POS_W-1:0] pos_t;
	localparam pos_t POS_MAX = {POS_W{1'b1}};

	typedef logic [5:0] tk_t;
	typedef logic [1:0] kind_t;

	localparam kind_t K_TEXT  = 2'd0;
	localparam kind_t K_TOKEN = 2'd1;
	localparam kind_t K_ERROR = 2'd2;

	localparam logic E_BAD_CHAR  = 1'b0;
	localparam logic E_LONG_CHAR = 1'b1;

	localparam tk_t TK_IDENT  = 6'd0;
	localparam tk_t TK_INT    = 6'd1;
	localparam tk_t TK_DOUBLE = 6'd2;
	localparam tk_t TK_STRING = 6'd3;
	localparam tk_t TK_CHAR   = 6'd4;
	localparam tk_t TK_INC    = 6'd5;
	localparam tk_t TK_ADD_EQ = 6'd6;
	localparam tk_t TK_ADD    = 6'd7;
	localparam tk_t TK_DEC    = 6'd8;
	localparam tk_t TK_SUB_EQ = 6'd9;
	localparam tk_t TK_ARROW  = 6'd10;
	localparam tk_t TK_SUB    = 6'd11;
	localparam tk_t TK_MUL_EQ = 6'd12;
	localparam tk_t TK_MUL    = 6'd13;
	localparam tk_t TK_DIV_EQ = 6'd14;
	localparam tk_t TK_DIV    = 6'd15;
	localparam tk_t TK_MOD_EQ = 6'd16;
	localparam tk_t TK_MOD    = 6'd17;
	localparam tk_t TK_LOR    = 6'd18;
	localparam tk_t TK_OR_EQ  = 6'd19;
	localparam tk_t TK_OR     = 6'd20;
	localparam tk_t TK_LAND   = 6'd21;
	localparam tk_t TK_AND_EQ = 6'd22;
	localparam tk_t TK_AND    = 6'd23;
	localparam tk_t TK_XOR_EQ = 6'd24;
	localparam tk_t TK_XOR    = 6'd25;
	localparam tk_t TK_SHR_EQ = 6'd26;
	localparam tk_t TK_SHR    = 6'd27;
	localparam tk_t TK_GE     = 6'd28;
	localparam tk_t TK_GT     = 6'd29;
	localparam tk_t TK_SHL_EQ = 6'd30;
	localparam tk_t TK_SHL    = 6'd31;
	localparam tk_t TK_LE     = 6'd32;
	localparam tk_t TK_LT     = 6'd33;
	localparam tk_t TK_EQ     = 6'd34;
	localparam tk_t TK_ASSIGN = 6'd35;
	localparam tk_t TK_NE     = 6'd36;
	localparam tk_t TK_NOT    = 6'd37;
	localparam tk_t TK_QUEST  = 6'd38;
	localparam tk_t TK_AT     = 6'd39;
	localparam tk_t TK_PASTE  = 6'd40;
	localparam tk_t TK_HASH   = 6'd41;
	localparam tk_t TK_COLON  = 6'd42;
	localparam tk_t TK_TILDE  = 6'd43;
	localparam tk_t TK_SEMI   = 6'd44;
	localparam tk_t TK_COMMA  = 6'd45;
	localparam tk_t TK_DOT    = 6'd46;
	localparam tk_t TK_LBRACE = 6'd47;
	localparam tk_t TK_RBRACE = 6'd48;
	localparam tk_t TK_LBRACK = 6'd49;
	localparam tk_t TK_RBRACK = 6'd50;
	localparam tk_t TK_LPAREN = 6'd51;
	localparam tk_t TK_RPAREN = 6'd52;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_NB1 = 8'hC2;
	localparam logic [7:0] CH_NB2 = 8'hA0;

	typedef enum logic [3:0] {
		M_START, M_IDENT, M_OPER, M_INT, M_HEX, M_FIXED, M_DOUBLE,
		M_CHAR, M_STRING, M_MCOMMENT, M_SCOMMENT
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] held_byte;
		logic       held_valid;
		logic [7:0] op0;
		logic [7:0] op1;
		logic [1:0] op_cnt;
		pos_t       cur_line;
		pos_t       cur_col;
		pos_t       tok_line;
		pos_t       tok_col;
		pos_t       op_col;
		logic [1:0] flags;
		logic       esc;
		logic [1:0] chr_cnt;
		pos_t       lit_len;
		logic       started;
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  text;
		tk_t         tk;
		logic [15:0] line;
		logic [15:0] col;
		logic        line_start;
		logic        after_sp;
		logic        err;
	} res_t;

	typedef struct packed {
		res_t [3:0] res;
		logic [2:0] nres;
	} batch_t;

	typedef struct packed {
		state_t     st;
		batch_t     b;
		logic       taken;
	} work_t;

	typedef struct packed {
		tk_t        code;
		logic [1:0] len;
	} opc_t;

	function automatic state_t reset_state();
		state_t s;
		s = '0;
		s.mode     = M_START;
		s.cur_line = pos_t'(1);
		s.tok_line = pos_t'(1);
		s.flags    = 2'b01;
		return s;
	endfunction

	function automatic pos_t sat_inc(pos_t v);
		return (v == POS_MAX) ? v : v + pos_t'(1);
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic is_single(logic [7:0] c);
		logic r;
		case (c) inside
			"?", "@", ":", "~", ";", ",", ".", "{", "}", "[", "]", "(", ")": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_punct(logic [7:0] c);
		logic r;
		case (c) inside
			"+", "-", "*", "/", "%", "|", "&", "^", ">", "<", "=", "!", "#": r = 1'b1;
			default: r = is_single(c);
		endcase
		return r;
	endfunction

	function automatic logic [1:0] op_needed(logic [7:0] a, logic [7:0] b);
		logic [1:0] r;
		if (is_single(a))
			r = 2'd1;
		else if ((a == ">" || a == "<") && b == a)
			r = 2'd3;
		else
			r = 2'd2;
		return r;
	endfunction

	function automatic opc_t pick(logic hit, tk_t code2, tk_t code1);
		opc_t r;
		r.code = hit ? code2 : code1;
		r.len  = hit ? 2'd2 : 2'd1;
		return r;
	endfunction

	function automatic opc_t op_code(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		opc_t r;
		r.code = TK_RPAREN;
		r.len  = 2'd1;
		case (a)
			"+": r = (b == "+") ? pick(1'b1, TK_INC, TK_ADD) : pick(b == "=", TK_ADD_EQ, TK_ADD);
			"-": begin
				if (b == "-")
					r = pick(1'b1, TK_DEC, TK_SUB);
				else if (b == "=")
					r = pick(1'b1, TK_SUB_EQ, TK_SUB);
				else
					r = pick(b == ">", TK_ARROW, TK_SUB);
			end
			"*": r = pick(b == "=", TK_MUL_EQ, TK_MUL);
			"/": r = pick(b == "=", TK_DIV_EQ, TK_DIV);
			"%": r = pick(b == "=", TK_MOD_EQ, TK_MOD);
			"|": r = (b == "|") ? pick(1'b1, TK_LOR, TK_OR) : pick(b == "=", TK_OR_EQ, TK_OR);
			"&": r = (b == "&") ? pick(1'b1, TK_LAND, TK_AND) : pick(b == "=", TK_AND_EQ, TK_AND);
			"^": r = pick(b == "=", TK_XOR_EQ, TK_XOR);
			">": begin
				if (b == ">") begin
					r = pick(1'b1, TK_SHR, TK_SHR);
					if (c == "=") begin
						r.code = TK_SHR_EQ;
						r.len  = 2'd3;
					end
				end else
					r = pick(b == "=", TK_GE, TK_GT);
			end
			"<": begin
				if (b == "<") begin
					r = pick(1'b1, TK_SHL, TK_SHL);
					if (c == "=") begin
						r.code = TK_SHL_EQ;
						r.len  = 2'd3;
					end
				end else
					r = pick(b == "=", TK_LE, TK_LT);
			end
			"=": r = pick(b == "=", TK_EQ, TK_ASSIGN);
			"!": r = pick(b == "=", TK_NE, TK_NOT);
			"?": r.code = TK_QUEST;
			"@": r.code = TK_AT;
			"#": r = pick(b == "#", TK_PASTE, TK_HASH);
			":": r.code = TK_COLON;
			"~": r.code = TK_TILDE;
			";": r.code = TK_SEMI;
			",": r.code = TK_COMMA;
			".": r.code = TK_DOT;
			"{": r.code = TK_LBRACE;
			"}": r.code = TK_RBRACE;
			"[": r.code = TK_LBRACK;
			"]": r.code = TK_RBRACK;
			"(": r.code = TK_LPAREN;
			default: r.code = TK_RPAREN;
		endcase
		return r;
	endfunction

	function automatic work_t put(work_t w, kind_t kind, logic [7:0] text, tk_t tk,
			pos_t line, pos_t col, logic [1:0] fl, logic err);
		work_t r;
		res_t  e;
		r = w;
		e.kind       = kind;
		e.text       = text;
		e.tk         = tk;
		e.line       = line[15:0];
		e.col        = col[15:0];
		e.line_start = fl[0];
		e.after_sp   = fl[1];
		e.err        = err;
		if (r.b.nres < 3'd4) begin
			r.b.res[r.b.nres[1:0]] = e;
			r.b.nres = r.b.nres + 3'd1;
		end
		return r;
	endfunction

	function automatic work_t text_out(work_t w, logic [7:0] c);
		work_t r;
		r = put(w, K_TEXT, c, TK_IDENT, w.st.tok_line, w.st.tok_col, 2'b00, 1'b0);
		r.st.lit_len = sat_inc(r.st.lit_len);
		if (r.st.chr_cnt != 2'd3)
			r.st.chr_cnt = r.st.chr_cnt + 2'd1;
		return r;
	endfunction

	function automatic work_t record(work_t w, tk_t tk);
		work_t r;
		r = put(w, K_TOKEN, 8'h00, tk, w.st.tok_line, w.st.tok_col, w.st.flags, 1'b0);
		r.st.flags = 2'b00;
		return r;
	endfunction

	function automatic work_t begin_token(work_t w);
		work_t r;
		r = w;
		r.st.tok_line = w.st.cur_line;
		r.st.tok_col  = w.st.cur_col;
		r.st.op_col   = w.st.cur_col;
		r.st.lit_len  = '0;
		r.st.chr_cnt  = 2'd0;
		return r;
	endfunction

	function automatic work_t escape_out(work_t w, logic [7:0] c);
		work_t r;
		case (c) inside
			"\\", "\"", "'": r = text_out(w, c);
			"t": r = text_out(w, CH_TAB);
			"s": r = text_out(w, " ");
			"n": r = text_out(w, CH_LF);
			"r": r = text_out(w, CH_CR);
			"b": r = text_out(w, CH_BS);
			default: r = w;
		endcase
		return r;
	endfunction

	// Push an operator byte and split off every operator that is settled.
	function automatic work_t op_apply(work_t w, logic [7:0] c, logic push, logic fin);
		work_t          r;
		logic [2:0][7:0] ob;
		logic [1:0]     n;
		logic [1:0]     len;
		logic [7:0]     a;
		logic [7:0]     b;
		logic [7:0]     cc;
		logic           done;
		opc_t           oc;
		r = w;
		ob = {8'h00, w.st.op1, w.st.op0};
		n = (w.st.op_cnt > 2'd2) ? 2'd2 : w.st.op_cnt;
		if (push) begin
			ob[n] = c;
			n = n + 2'd1;
		end
		done = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (!done && n != 2'd0) begin
				a  = ob[0];
				b  = (n > 2'd1) ? ob[1] : 8'h00;
				cc = (n > 2'd2) ? ob[2] : 8'h00;
				if (!fin && n < op_needed(a, b))
					done = 1'b1;
				else begin
					oc = op_code(a, b, cc);
					len = (oc.len > n) ? n : oc.len;
					r = put(r, K_TOKEN, 8'h00, oc.code, r.st.tok_line, r.st.op_col,
						r.st.flags, 1'b0);
					r.st.flags = 2'b00;
					for (int j = 0; j < 3; j++)
						if (2'(j) < len)
							r.st.op_col = sat_inc(r.st.op_col);
					case (len)
						2'd1: ob = {8'h00, ob[2], ob[1]};
						2'd2: ob = {8'h00, 8'h00, ob[2]};
						default: ob = '0;
					endcase
					n = n - len;
				end
			end
		end
		r.st.op0 = ob[0];
		r.st.op1 = ob[1];
		r.st.op_cnt = n;
		return r;
	endfunction

	function automatic work_t number_exp(work_t w, logic [7:0] c, logic [7:0] nx);
		work_t r;
		r = text_out(w, c);
		r.st.mode = M_DOUBLE;
		if (nx == "-" || nx == "+") begin
			r = text_out(r, nx);
			r.taken = 1'b1;
		end
		return r;
	endfunction

	// One byte with its lookahead; taken marks that the lookahead was used up.
	function automatic work_t process(work_t w, logic [7:0] c, logic [7:0] nx);
		work_t r;
		logic  again;
		pos_t  col;
		r = w;
		r.taken = 1'b0;
		if (r.st.esc) begin
		end else if (!r.st.started)
			r.st.started = 1'b1;
		else if (c == CH_LF) begin
			r.st.cur_line = sat_inc(r.st.cur_line);
			r.st.cur_col  = '0;
		end else
			r.st.cur_col = sat_inc(r.st.cur_col);
		again = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (again) begin
				again = 1'b0;
				unique case (r.st.mode) inside
					M_START: begin
						if (is_letter(c)) begin
							r = begin_token(r);
							r.st.mode = M_IDENT;
							again = 1'b1;
						end else if (is_digit(c)) begin
							r = begin_token(r);
							r.st.mode = M_INT;
							again = 1'b1;
						end else if (c == "'") begin
							r = begin_token(r);
							r.st.mode = M_CHAR;
						end else if (c == "\"") begin
							r = begin_token(r);
							r.st.mode = M_STRING;
						end else if (c == CH_CR || c == CH_LF)
							r.st.flags = 2'b11;
						else if (c == " " || c == CH_TAB || c == CH_NB1 || c == CH_NB2)
							r.st.flags = r.st.flags | 2'b10;
						else if (c == "/" && nx == "/") begin
							r.st.mode = M_SCOMMENT;
							r.taken = 1'b1;
						end else if (c == "/" && nx == "*") begin
							r.st.mode = M_MCOMMENT;
							r.taken = 1'b1;
						end else if (c == ".") begin
							r = begin_token(r);
							if (is_digit(nx)) begin
								r.st.mode = M_INT;
								again = 1'b1;
							end else begin
								r.st.mode = M_OPER;
								r = op_apply(r, c, 1'b1, 1'b0);
							end
						end else if (is_punct(c)) begin
							r = begin_token(r);
							r.st.mode = M_OPER;
							again = 1'b1;
						end else
							r = put(r, K_ERROR, 8'h00, TK_IDENT, r.st.cur_line,
								r.st.cur_col, 2'b00, E_BAD_CHAR);
					end
					M_IDENT: begin
						if (is_letter(c) || is_digit(c))
							r = text_out(r, c);
						else begin
							r = record(r, TK_IDENT);
							r.st.mode = M_START;
							again = 1'b1;
						end
					end
					M_OPER: begin
						if (is_punct(c) && !(c == "/" && (nx == "/" || nx == "*")))
							r = op_apply(r, c, 1'b1, 1'b0);
						else begin
							r = op_apply(r, 8'h00, 1'b0, 1'b1);
							r.st.mode = M_START;
							again = 1'b1;
						end
					end
					M_INT: begin
						if (is_digit(c) || c == "u" || c == "U")
							r = text_out(r, c);
						else if (c == ".") begin
							r = text_out(r, c);
							r.st.mode = M_FIXED;
						end else if (c == "e" || c == "E")
							r = number_exp(r, c, nx);
						else if (c == "x") begin
							r = text_out(r, c);
							r.st.mode = M_HEX;
						end else begin
							r = record(r, TK_INT);
							r.st.mode = M_START;
							again = 1'b1;
						end
					end
					M_HEX: begin
						if (is_hex(c))
							r = text_out(r, c);
						else begin
							r = record(r, TK_INT);
							r.st.mode = M_START;
							again = 1'b1;
						end
					end
					M_FIXED: begin
						if (is_digit(c))
							r = text_out(r, c);
						else if (c == "e" || c == "E")
							r = number_exp(r, c, nx);
						else begin
							r = record(r, TK_DOUBLE);
							r.st.mode = M_START;
							again = (c != "f");
						end
					end
					M_DOUBLE: begin
						if (is_digit(c))
							r = text_out(r, c);
						else begin
							r = record(r, TK_DOUBLE);
							r.st.mode = M_START;
							again = (c != "f");
						end
					end
					M_STRING, M_CHAR: begin
						if (r.st.esc) begin
							r.st.esc = 1'b0;
							r = escape_out(r, c);
						end else if (c == "\\")
							r.st.esc = 1'b1;
						else if (r.st.mode == M_STRING && c == "\"") begin
							r = record(r, TK_STRING);
							r.st.mode = M_START;
						end else if (r.st.mode == M_CHAR && c == "'") begin
							if (r.st.chr_cnt > 2'd1) begin
								col = (r.st.cur_col >= r.st.lit_len) ?
									r.st.cur_col - r.st.lit_len : '0;
								r = put(r, K_ERROR, 8'h00, TK_IDENT, r.st.cur_line, col,
									2'b00, E_LONG_CHAR);
							end
							r = record(r, TK_CHAR);
							r.st.mode = M_START;
						end else
							r = text_out(r, c);
					end
					M_SCOMMENT: begin
						if (c == CH_CR || c == CH_LF) begin
							r.st.mode = M_START;
							r.st.flags = 2'b11;
						end
					end
					M_MCOMMENT: begin
						if (c == "*" && nx == "/") begin
							r.st.mode = M_START;
							r.taken = 1'b1;
						end
					end
					default: begin
						r.st.mode = M_START;
						again = 1'b1;
					end
				endcase
			end
		end
		return r;
	endfunction

	// Whole effect of one input beat: the held byte against the new one, and
	// on the final byte a flush with a trailing space and a return to reset.
	function automatic work_t step(state_t st, logic [7:0] c, logic fin);
		work_t w;
		logic  tk1;
		logic  tk2;
		w = '0;
		w.st = st;
		tk1 = 1'b0;
		tk2 = 1'b0;
		if (st.held_valid) begin
			w = process(w, st.held_byte, c);
			tk1 = w.taken;
		end
		w.st.held_valid = !tk1;
		w.st.held_byte  = tk1 ? 8'h00 : c;
		if (fin) begin
			if (w.st.held_valid) begin
				w = process(w, w.st.held_byte, " ");
				tk2 = w.taken;
			end
			if (!tk2)
				w = process(w, " ", 8'h00);
			w.st = reset_state();
		end
		return w;
	endfunction

endpackage

// ===== hdl/clex_core.sv =====
// ----------------------------------------------------------------------------
// clex_core: lexer state register and single-pass byte step
// Computes the results of the registered input beat and commits the state.
// ----------------------------------------------------------------------------
module clex_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        char_s1,
	input  logic              end_s1,
	input  logic              advance,
	output clex_pkg::batch_t  batch
);

	clex_pkg::state_t st_q;
	clex_pkg::work_t  w;

	always_comb begin
		w = clex_pkg::step(st_q, char_s1, end_s1);
		batch = w.b;
	end

	// advance state only when the beat's results are taken by the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= clex_pkg::reset_state();
		else if (advance)
			st_q <= w.st;
	end

endmodule

// ===== hdl/clex_outbuf.sv =====
// ----------------------------------------------------------------------------
// clex_outbuf: result register for up to four results of one beat
// Holds one batch and hands it out one result per output beat.
// ----------------------------------------------------------------------------
module clex_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  clex_pkg::batch_t  batch,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_stall,
	output clex_pkg::res_t    head,
	output logic              last
);

	clex_pkg::res_t [3:0] slots_q;
	logic [2:0]           cnt_q;
	logic [1:0]           idx_q;
	logic                 pop;

	assign out_valid = cnt_q != 3'd0;
	assign pop       = out_valid && !out_stall;
	assign head      = slots_q[idx_q];
	assign last      = cnt_q == 3'd1;
	assign can_load  = (cnt_q == 3'd0) || (cnt_q == 3'd1 && !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= batch.nres;
			idx_q <= 2'd0;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			slots_q <= batch.res;
	end

endmodule

// ===== hdl/c_style_lexer.sv =====
// ----------------------------------------------------------------------------
// c_style_lexer: streaming lexer for C-style source text
// Turns a byte stream into text bytes, token records and error records.
// ----------------------------------------------------------------------------
// Input channel: one source byte per beat on char_in, end_of_text high on the
// final byte of a text. Output channel: one result per beat; kind selects a
// text byte, a token record or an error record, and last_of_run marks the
// final result caused by one input beat.
// Each byte is judged against the byte after it, so the results of a byte
// appear once the next byte (or end_of_text) has arrived.
// Path: an input beat sits in the input register, and its results are loaded
// into the result register, which offers them, as soon as it can take them.
// Throughput: one input beat per cycle while each beat gives at most one
// result and out_stall is low; after a beat with more results the next beat
// waits in the input register while the result register hands out one result
// per cycle (none while out_stall is high) until it is down to its last one.
// Stall: out_stall holds the current result; once the result register cannot
// take the next batch, in_stall rises and the input register holds its beat.
// Reset: arst_n clears all control state and returns the lexer to line 1,
// column 0, start of line. After end_of_text the lexer returns to that state
// on its own.
// ----------------------------------------------------------------------------
module c_style_lexer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  text_byte,
	output logic [5:0]  token_kind,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic        at_line_start,
	output logic        after_space,
	output logic        error_code,
	output logic        last_of_run
);

	logic             s1_valid_q;
	logic [7:0]       char_s1;
	logic             end_s1;
	logic             advance;
	logic             can_load;
	logic             accept;
	clex_pkg::batch_t batch;
	clex_pkg::res_t   head;

	// A beat leaves the input register once its results fit; a beat with no
	// result only updates the lexer state and never waits.
	assign advance  = s1_valid_q && (batch.nres == 3'd0 || can_load);
	assign in_stall = s1_valid_q && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (accept)
			s1_valid_q <= 1'b1;
		else if (advance)
			s1_valid_q <= 1'b0;
	end

	// hold the payload of the beat in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_in;
			end_s1  <= end_of_text;
		end
	end

	clex_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_s1 (char_s1),
		.end_s1  (end_s1),
		.advance (advance),
		.batch   (batch)
	);

	clex_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && batch.nres != 3'd0),
		.batch     (batch),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head),
		.last      (last_of_run)
	);

	assign kind          = head.kind;
	assign text_byte     = head.text;
	assign token_kind    = head.tk;
	assign start_line    = head.line;
	assign start_column  = head.col;
	assign at_line_start = head.line_start;
	assign after_space   = head.after_sp;
	assign error_code    = head.err;

endmodule
